[sv/spqf_pkg.sv]
// ----------------------------------------------------------------------------
// spqf_pkg
// Shared types and constants of the sub-pixel peak quadratic fit block.
// ----------------------------------------------------------------------------
package spqf_pkg;

  // Width of the offset fields on the result channel.
  localparam int OFFSET_BITS = 16;

  typedef enum logic [1:0] {
    ST_REFINED    = 2'd0,
    ST_OFF_CENTRE = 2'd1,
    ST_POOR_FIT   = 2'd2
  } fit_status_e;

endpackage

[sv/spqf_if.sv]
// ----------------------------------------------------------------------------
// spqf window and result channels
// Valid/ready channels for the 3x3 sample window and the fit result.
// ----------------------------------------------------------------------------
interface spqf_win_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_r0_c0;
  logic signed [SAMPLE_BITS-1:0] sample_r0_c1;
  logic signed [SAMPLE_BITS-1:0] sample_r0_c2;
  logic signed [SAMPLE_BITS-1:0] sample_r1_c0;
  logic signed [SAMPLE_BITS-1:0] sample_r1_c1;
  logic signed [SAMPLE_BITS-1:0] sample_r1_c2;
  logic signed [SAMPLE_BITS-1:0] sample_r2_c0;
  logic signed [SAMPLE_BITS-1:0] sample_r2_c1;
  logic signed [SAMPLE_BITS-1:0] sample_r2_c2;

  modport source (
    output valid, sample_r0_c0, sample_r0_c1, sample_r0_c2, sample_r1_c0,
           sample_r1_c1, sample_r1_c2, sample_r2_c0, sample_r2_c1, sample_r2_c2,
    input  ready
  );
  modport sink (
    input  valid, sample_r0_c0, sample_r0_c1, sample_r0_c2, sample_r1_c0,
           sample_r1_c1, sample_r1_c2, sample_r2_c0, sample_r2_c1, sample_r2_c2,
    output ready
  );
endinterface

interface spqf_res_if ();
  logic                                     valid;
  logic                                     ready;
  logic signed [spqf_pkg::OFFSET_BITS-1:0]  offset_x;
  logic signed [spqf_pkg::OFFSET_BITS-1:0]  offset_y;
  logic [1:0]                               fit_status;

  modport source (output valid, offset_x, offset_y, fit_status, input ready);
  modport sink   (input valid, offset_x, offset_y, fit_status, output ready);
endinterface

[sv/subpixel_peak_quadratic_fit.sv]
// ----------------------------------------------------------------------------
// subpixel_peak_quadratic_fit
// Sub-pixel peak refinement by a least-squares quadratic fit over a 3x3 window.
// ----------------------------------------------------------------------------
// Usage:
//   win_i carries one 3x3 window of signed samples per item; res_o returns one
//   item per window with the column and row offsets (FRACTION_BITS fraction
//   bits, rounded to nearest) and a status: refined, maximum not at the
//   center, or poor/degenerate fit (offsets are zero unless refined).
//   From acceptance to res_o.valid an item passes three stages of sums,
//   products and the surface terms, then one restoring-divider stage per
//   quotient bit, then the rounding and output register.
//   Throughput is one item per cycle while res_o is not stalled; every
//   stage is a fully pipelined register stage, so a new window may enter
//   in every cycle unless the pipeline holds.
//   When the receiver holds res_o.ready low with a valid result, the whole
//   pipeline holds and win_i.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; no result is shown until an item flows
//   through.
// ----------------------------------------------------------------------------
module subpixel_peak_quadratic_fit #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spqf_win_if.sink   win_i,
  spqf_res_if.source res_o
);

  localparam int SW = SAMPLE_BITS;
  localparam int AW = SW + 4;       // 6a, 6b
  localparam int CW = SW + 3;       // 6c, 6d
  localparam int EW = SW + 3;       // 4e
  localparam int PW = 2 * SW + 12;  // denominator and numerators

  logic en;
  assign en          = !res_o.valid || res_o.ready;
  assign win_i.ready = en;

  // Stage 1: maximum check and the fit terms.
  logic signed [SW-1:0] v [9];
  logic signed [AW-1:0] a_d, b_d;
  logic signed [CW-1:0] cx_d, cy_d;
  logic signed [EW-1:0] e_d;
  logic                 centre_d;

  assign v[0] = win_i.sample_r0_c0;
  assign v[1] = win_i.sample_r0_c1;
  assign v[2] = win_i.sample_r0_c2;
  assign v[3] = win_i.sample_r1_c0;
  assign v[4] = win_i.sample_r1_c1;
  assign v[5] = win_i.sample_r1_c2;
  assign v[6] = win_i.sample_r2_c0;
  assign v[7] = win_i.sample_r2_c1;
  assign v[8] = win_i.sample_r2_c2;

  always_comb begin
    // Earlier samples win a tie, so the center must beat them strictly.
    centre_d = (v[4] > v[0]) && (v[4] > v[1]) && (v[4] > v[2]) && (v[4] > v[3]) &&
               (v[4] >= v[5]) && (v[4] >= v[6]) && (v[4] >= v[7]) && (v[4] >= v[8]);
    a_d  = AW'(v[0]) + AW'(v[3]) + AW'(v[6]) + AW'(v[2]) + AW'(v[5]) + AW'(v[8])
         - ((AW'(v[1]) + AW'(v[4]) + AW'(v[7])) <<< 1);
    b_d  = AW'(v[0]) + AW'(v[1]) + AW'(v[2]) + AW'(v[6]) + AW'(v[7]) + AW'(v[8])
         - ((AW'(v[3]) + AW'(v[4]) + AW'(v[5])) <<< 1);
    cx_d = (CW'(v[2]) + CW'(v[5]) + CW'(v[8])) - (CW'(v[0]) + CW'(v[3]) + CW'(v[6]));
    cy_d = (CW'(v[6]) + CW'(v[7]) + CW'(v[8])) - (CW'(v[0]) + CW'(v[1]) + CW'(v[2]));
    e_d  = EW'(v[0]) - EW'(v[2]) - EW'(v[6]) + EW'(v[8]);
  end

  logic                 vld1_q, centre1_q;
  logic signed [AW-1:0] a_q, b_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [EW-1:0] e_q;

  // Stage 2: products.
  logic                      vld2_q, centre2_q;
  logic signed [2*AW-1:0]    ab_q;
  logic signed [2*EW-1:0]    ee_q;
  logic signed [AW+CW-1:0]   bcx_q, acy_q;
  logic signed [CW+EW-1:0]   cye_q, cxe_q;

  // Stage 3: denominator, numerators and the early status.
  logic                 vld3_q;
  logic signed [PW-1:0] den_q, nx_q, ny_q;
  logic [1:0]           st3_q;
  logic signed [PW-1:0] den_d, nx_d, ny_d;
  logic [1:0]           st3_d;

  always_comb begin
    den_d = (PW'(ab_q) <<< 4) - ((PW'(ee_q) <<< 3) + PW'(ee_q));
    nx_d  = (PW'(bcx_q) <<< 3) - ((PW'(cye_q) <<< 2) + (PW'(cye_q) <<< 1));
    ny_d  = (PW'(acy_q) <<< 3) - ((PW'(cxe_q) <<< 2) + (PW'(cxe_q) <<< 1));
    priority if (!centre2_q) begin
      st3_d = spqf_pkg::ST_OFF_CENTRE;
    end else if (den_d == '0) begin
      st3_d = spqf_pkg::ST_POOR_FIT;
    end else begin
      st3_d = spqf_pkg::ST_REFINED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= win_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      centre1_q <= centre_d;
      a_q       <= a_d;
      b_q       <= b_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      e_q       <= e_d;

      centre2_q <= centre1_q;
      ab_q      <= a_q * b_q;
      ee_q      <= e_q * e_q;
      bcx_q     <= b_q * cx_q;
      acy_q     <= a_q * cy_q;
      cye_q     <= cy_q * e_q;
      cxe_q     <= cx_q * e_q;

      den_q     <= den_d;
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      st3_q     <= st3_d;
    end
  end

  spqf_quot_pipe #(
    .PW            (PW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_quot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld3_q),
    .nx_i       (nx_q),
    .ny_i       (ny_q),
    .den_i      (den_q),
    .status_i   (st3_q),
    .valid_o    (res_o.valid),
    .offset_x_o (res_o.offset_x),
    .offset_y_o (res_o.offset_y),
    .status_o   (res_o.fit_status)
  );

endmodule

[sv/spqf_quot_pipe.sv]
// ----------------------------------------------------------------------------
// spqf_quot_pipe
// Pipelined restoring divider that forms both rounded offsets -nx/den and
// -ny/den, one quotient bit per stage, and settles the final status.
// ----------------------------------------------------------------------------
module spqf_quot_pipe #(
  parameter int PW            = 44,
  parameter int FRACTION_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [PW-1:0]                    nx_i,
  input  logic signed [PW-1:0]                    ny_i,
  input  logic signed [PW-1:0]                    den_i,
  input  logic [1:0]                              status_i,
  output logic                                    valid_o,
  output logic signed [spqf_pkg::OFFSET_BITS-1:0] offset_x_o,
  output logic signed [spqf_pkg::OFFSET_BITS-1:0] offset_y_o,
  output logic [1:0]                              status_o
);

  localparam int NS = FRACTION_BITS + 1;  // fraction steps plus rounding bit
  localparam int QW = FRACTION_BITS + 2;  // integer bit, fraction, round bit
  localparam int OB = spqf_pkg::OFFSET_BITS;
  localparam int XW = QW + OB + 2;

  logic [PW-1:0] rx_q  [NS+1];
  logic [PW-1:0] ry_q  [NS+1];
  logic [PW-1:0] d_q   [NS+1];
  logic [QW-1:0] qx_q  [NS+1];
  logic [QW-1:0] qy_q  [NS+1];
  logic          negx_q[NS+1];
  logic          negy_q[NS+1];
  logic          fail_q[NS+1];
  logic [1:0]    st_q  [NS+1];
  logic          vld_q [NS+1];

  // First stage: magnitudes, sign of the result and the integer step.
  logic [PW-1:0] absx, absy, absd;
  logic [PW-1:0] r0x_d, r0y_d;
  logic          q0x, q0y;

  always_comb begin
    absx  = nx_i[PW-1]  ? PW'(-nx_i)  : PW'(nx_i);
    absy  = ny_i[PW-1]  ? PW'(-ny_i)  : PW'(ny_i);
    absd  = den_i[PW-1] ? PW'(-den_i) : PW'(den_i);
    q0x   = (absx >= absd);
    q0y   = (absy >= absd);
    r0x_d = q0x ? absx - absd : absx;
    r0y_d = q0y ? absy - absd : absy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= r0x_d;
      ry_q[0]   <= r0y_d;
      d_q[0]    <= absd;
      qx_q[0]   <= QW'(q0x);
      qy_q[0]   <= QW'(q0y);
      negx_q[0] <= (nx_i[PW-1] == den_i[PW-1]);
      negy_q[0] <= (ny_i[PW-1] == den_i[PW-1]);
      // A magnitude above one is a poor fit; exactly one is kept.
      fail_q[0] <= (absx > absd) || (absy > absd);
      st_q[0]   <= status_i;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_step
    logic [PW:0]   shx, shy;
    logic          gex, gey;
    logic [PW-1:0] rx_d, ry_d;

    always_comb begin
      shx  = {rx_q[i-1], 1'b0};
      shy  = {ry_q[i-1], 1'b0};
      gex  = (shx >= {1'b0, d_q[i-1]});
      gey  = (shy >= {1'b0, d_q[i-1]});
      rx_d = gex ? PW'(shx - {1'b0, d_q[i-1]}) : PW'(shx);
      ry_d = gey ? PW'(shy - {1'b0, d_q[i-1]}) : PW'(shy);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i]   <= rx_d;
        ry_q[i]   <= ry_d;
        d_q[i]    <= d_q[i-1];
        qx_q[i]   <= {qx_q[i-1][QW-2:0], gex};
        qy_q[i]   <= {qy_q[i-1][QW-2:0], gey};
        negx_q[i] <= negx_q[i-1];
        negy_q[i] <= negy_q[i-1];
        fail_q[i] <= fail_q[i-1];
        st_q[i]   <= st_q[i-1];
      end
    end
  end

  // Last stage: round half away from zero, apply the sign, settle status.
  logic [QW:0]          rndx, rndy;
  logic signed [XW-1:0] sx, sy;
  logic [1:0]           st_d;
  logic                 vld_out_q;
  logic signed [OB-1:0] ox_q, oy_q;
  logic [1:0]           st_out_q;

  always_comb begin
    rndx = ({1'b0, qx_q[NS]} + (QW+1)'(1)) >> 1;
    rndy = ({1'b0, qy_q[NS]} + (QW+1)'(1)) >> 1;
    sx   = negx_q[NS] ? -$signed(XW'(rndx)) : $signed(XW'(rndx));
    sy   = negy_q[NS] ? -$signed(XW'(rndy)) : $signed(XW'(rndy));
    st_d = st_q[NS];
    if (st_q[NS] == spqf_pkg::ST_REFINED && fail_q[NS]) begin
      st_d = spqf_pkg::ST_POOR_FIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_out_q <= st_d;
      if (st_d == spqf_pkg::ST_REFINED) begin
        ox_q <= sx[OB-1:0];
        oy_q <= sy[OB-1:0];
      end else begin
        ox_q <= '0;
        oy_q <= '0;
      end
    end
  end

  assign valid_o    = vld_out_q;
  assign offset_x_o = ox_q;
  assign offset_y_o = oy_q;
  assign status_o   = st_out_q;

endmodule

[sim/spqf_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window and result channel types for the quadratic fit testbench
// The block's channel interfaces come from the RTL; this file holds the
// item types that the stimulus and the checker share.
// ----------------------------------------------------------------------------
package spqf_tb_pkg;

  typedef struct {
    logic signed [15:0] smp [9];
  } window_t;

  typedef struct {
    logic signed [15:0]    offset_x;
    logic signed [15:0]    offset_y;
    spqf_pkg::fit_status_e status;
  } peak_fit_t;
endpackage

[sim/subpixel_peak_quadratic_fit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of subpixel_peak_quadratic_fit
// Sends 3x3 windows through the valid/ready input, predicts each peak fit
// with an exact integer model and checks every result item in order, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module subpixel_peak_quadratic_fit_tb;

  localparam int FRAC_BITS = 14;
  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;

  spqf_win_if #(.SAMPLE_BITS(16)) win ();
  spqf_res_if res ();

  subpixel_peak_quadratic_fit #(
    .SAMPLE_BITS(16),
    .FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .win_i (win),
    .res_o (res)
  );

  spqf_tb_pkg::window_t   pending_windows [$];
  spqf_tb_pkg::peak_fit_t expected_fits [$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        errors;
  int        n_windows;
  int        n_results;
  int        n_status [3];
  int        quiet_cycles;
  bit        win_taken;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void queue_window(input spqf_tb_pkg::window_t w);
    pending_windows = {pending_windows, w};
  endfunction

  function automatic void queue_expected(input spqf_tb_pkg::peak_fit_t f);
    expected_fits = {expected_fits, f};
  endfunction

  // Returns false when |num/den| exceeds one; otherwise q = -num/den rounded.
  function automatic bit scaled_quot(input logic signed [127:0] num,
                                     input logic signed [127:0] den,
                                     output logic [15:0] q);
    logic [127:0] rn;
    logic [127:0] dn;
    logic [127:0] qq;
    bit           neg;
    neg = (num[127] == den[127]);
    rn  = num[127] ? -num : num;
    dn  = den[127] ? -den : den;
    q   = '0;
    if (rn > dn) return 1'b0;
    qq = (rn << (FRAC_BITS + 1)) / dn;
    qq = (qq + 1) >> 1;
    q  = neg ? -qq[15:0] : qq[15:0];
    return 1'b1;
  endfunction

  function automatic spqf_tb_pkg::peak_fit_t fit_peak(input spqf_tb_pkg::window_t w);
    longint     v [9];
    longint     s, sx2, sy2, cx, cy, exy, a6, b6;
    logic signed [127:0] den, nx, ny;
    logic [15:0] qx, qy;
    spqf_tb_pkg::peak_fit_t r;
    int         best;
    best = 0;
    for (int i = 0; i < 9; i++) v[i] = longint'(w.smp[i]);
    for (int i = 1; i < 9; i++) if (v[i] > v[best]) best = i;
    r.offset_x = '0;
    r.offset_y = '0;
    r.status   = spqf_pkg::ST_REFINED;
    if (best != 4) begin
      r.status = spqf_pkg::ST_OFF_CENTRE;
      return r;
    end
    s = 0;
    for (int i = 0; i < 9; i++) s += v[i];
    sx2 = v[0] + v[3] + v[6] + v[2] + v[5] + v[8];
    sy2 = v[0] + v[1] + v[2] + v[6] + v[7] + v[8];
    cx  = (v[2] + v[5] + v[8]) - (v[0] + v[3] + v[6]);
    cy  = (v[6] + v[7] + v[8]) - (v[0] + v[1] + v[2]);
    exy = v[0] - v[2] - v[6] + v[8];
    a6  = 3 * sx2 - 2 * s;
    b6  = 3 * sy2 - 2 * s;
    // All terms stay well inside 64 bits for 16-bit samples.
    den = 16 * a6 * b6 - 9 * exy * exy;
    nx  = 8 * b6 * cx - 6 * cy * exy;
    ny  = 8 * a6 * cy - 6 * cx * exy;
    if (den == 0) begin
      r.status = spqf_pkg::ST_POOR_FIT;
    end else if (!scaled_quot(nx, den, qx) || !scaled_quot(ny, den, qy)) begin
      r.status = spqf_pkg::ST_POOR_FIT;
    end else begin
      r.offset_x = qx;
      r.offset_y = qy;
    end
    return r;
  endfunction

  function automatic spqf_tb_pkg::window_t make_window(input int c0, c1, c2, c3, c4,
                                                       c5, c6, c7, c8);
    spqf_tb_pkg::window_t w;
    w.smp[0] = 16'(c0); w.smp[1] = 16'(c1); w.smp[2] = 16'(c2);
    w.smp[3] = 16'(c3); w.smp[4] = 16'(c4); w.smp[5] = 16'(c5);
    w.smp[6] = 16'(c6); w.smp[7] = 16'(c7); w.smp[8] = 16'(c8);
    return w;
  endfunction

  // Mostly peak-shaped windows so the fit path is exercised, plus noise.
  function automatic spqf_tb_pkg::window_t random_window();
    spqf_tb_pkg::window_t w;
    int      centre, spread, val;
    if ($urandom_range(0, 99) < 15) begin
      for (int i = 0; i < 9; i++) w.smp[i] = 16'($urandom);
      return w;
    end
    centre = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 3))
      0: spread = $urandom_range(1, 8);
      1: spread = $urandom_range(1, 300);
      2: spread = $urandom_range(1, 8000);
      default: spread = 65535;
    endcase
    for (int i = 0; i < 9; i++) begin
      val = centre - $urandom_range(0, spread);
      if ($urandom_range(0, 19) == 0) val = centre;
      if ($urandom_range(0, 29) == 0) val = centre + 1;
      if (val < -32768) val = -32768;
      if (val > 32767) val = 32767;
      w.smp[i] = 16'(val);
    end
    w.smp[4] = 16'(centre);
    return w;
  endfunction

  // Driver: a new item is presented only after the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!win.valid || win_taken) begin
        if (pending_windows.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          spqf_tb_pkg::window_t w;
          w = pending_windows.pop_front();
          win.valid        <= 1'b1;
          win.sample_r0_c0 <= w.smp[0];
          win.sample_r0_c1 <= w.smp[1];
          win.sample_r0_c2 <= w.smp[2];
          win.sample_r1_c0 <= w.smp[3];
          win.sample_r1_c1 <= w.smp[4];
          win.sample_r1_c2 <= w.smp[5];
          win.sample_r2_c0 <= w.smp[6];
          win.sample_r2_c1 <= w.smp[7];
          win.sample_r2_c2 <= w.smp[8];
        end else begin
          win.valid <= 1'b0;
        end
      end
      res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk_i) begin
    win_taken = 1'b0;
    if (rst_ni) begin
      if (win.valid && win.ready) begin
        spqf_tb_pkg::window_t w;
        w.smp[0] = win.sample_r0_c0; w.smp[1] = win.sample_r0_c1;
        w.smp[2] = win.sample_r0_c2; w.smp[3] = win.sample_r1_c0;
        w.smp[4] = win.sample_r1_c1; w.smp[5] = win.sample_r1_c2;
        w.smp[6] = win.sample_r2_c0; w.smp[7] = win.sample_r2_c1;
        w.smp[8] = win.sample_r2_c2;
        queue_expected(fit_peak(w));
        win_taken = 1'b1;
        n_windows++;
      end
      if (res.valid && res.ready) begin
        spqf_tb_pkg::peak_fit_t e;
        n_results++;
        if (expected_fits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time,
                   res.offset_x, res.offset_y, res.fit_status);
        end else begin
          e = expected_fits.pop_front();
          n_status[e.status]++;
          if (res.offset_x !== e.offset_x) begin
            errors++;
            $display("%0t: offset_x expected %0d actual %0d", $time,
                     e.offset_x, res.offset_x);
          end
          if (res.offset_y !== e.offset_y) begin
            errors++;
            $display("%0t: offset_y expected %0d actual %0d", $time,
                     e.offset_y, res.offset_y);
          end
          if (res.fit_status !== e.status) begin
            errors++;
            $display("%0t: fit_status expected %0d actual %0d", $time,
                     e.status, res.fit_status);
          end
        end
      end
      if ((win.valid && win.ready) || (res.valid && res.ready) ||
          (pending_windows.size() == 0 && expected_fits.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors        = 0;
    n_windows     = 0;
    n_results     = 0;
    n_status      = '{0, 0, 0};
    quiet_cycles  = 0;
    win_taken     = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 63;
    rst_ni        = 1'b0;
    win.valid     = 1'b0;
    win.sample_r0_c0 = '0; win.sample_r0_c1 = '0; win.sample_r0_c2 = '0;
    win.sample_r1_c0 = '0; win.sample_r1_c1 = '0; win.sample_r1_c2 = '0;
    win.sample_r2_c0 = '0; win.sample_r2_c1 = '0; win.sample_r2_c2 = '0;
    res.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Flat window: the first sample wins the tie.
    queue_window(make_window(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Extremes of the sample range.
    queue_window(make_window(-32768, -32768, -32768, -32768, 32767,
                             -32768, -32768, -32768, -32768));
    queue_window(make_window(32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767, 32767));
    queue_window(make_window(-32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768));
    queue_window(make_window(-1, -1, -1, -1, 0, -1, -1, -1, -1));
    // Center ties with a later sample: still counts as the maximum.
    queue_window(make_window(0, 5, 0, 3, 10, 10, 0, 4, 2));
    queue_window(make_window(1, 2, 3, 4, 10, 6, 7, 8, 10));
    // Center ties with an earlier sample: off center.
    queue_window(make_window(0, 10, 0, 3, 10, 2, 0, 4, 2));
    queue_window(make_window(10, 1, 1, 1, 10, 1, 1, 1, 1));
    // Maximum elsewhere.
    queue_window(make_window(0, 0, 0, 0, 5, 0, 0, 0, 32767));
    // Zero denominator: no curvature along x.
    queue_window(make_window(0, 0, 1, 9, 10, 9, 0, 0, 1));
    // Symmetric peak, shifted peaks and a broad ridge (offset beyond one).
    queue_window(make_window(0, 4, 0, 4, 9, 4, 0, 4, 0));
    queue_window(make_window(0, 4, 2, 3, 9, 8, 0, 4, 2));
    queue_window(make_window(2, 6, 0, 4, 9, 3, 1, 2, 0));
    queue_window(make_window(-30000, -100, 32000, -30000, 32767,
                             32766, -30000, -100, 32000));
    queue_window(make_window(100, 200, 100, 50, 32767, 32767, 0,
                             -32768, 0));
    queue_window(make_window(-21846, 21845, -21846, 21845, 32767,
                             21845, -21846, 21845, -21846));

    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 380; i++) queue_window(random_window());
      wait (pending_windows.size() == 0);
      if (phase == 0) begin
        send_idle_pct = 63;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (pending_windows.size() == 0 && !win.valid && expected_fits.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("Checked %0d windows, %0d results: %0d refined, %0d off center, %0d poor fit.",
             n_windows, n_results, n_status[0], n_status[1], n_status[2]);
    if (errors == 0 && expected_fits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_fits.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[subpixel_peak_quadratic_fit.f]
sv/spqf_pkg.sv
sv/spqf_if.sv
sv/spqf_quot_pipe.sv
sv/subpixel_peak_quadratic_fit.sv
sim/spqf_tb_if.sv
sim/subpixel_peak_quadratic_fit_tb.sv
